[rtl/core/stereo_flanger_delay_unit_macros.svh]
// Assertion macros shared by the flanger RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef STEREO_FLANGER_DELAY_UNIT_MACROS_SVH
`define STEREO_FLANGER_DELAY_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SFD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("flanger check failed");

// Next-cycle implication, disabled in reset.
`define SFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("flanger check failed");

`endif

[rtl/core/sfd_pkg.sv]
// Types, sequencing codes and arithmetic helpers for the stereo flanger.
// No dependencies; imported by sfd_lane and stereo_flanger_delay_unit.
package sfd_pkg;

   typedef struct packed {
      logic signed [23:0] left_in;
      logic signed [23:0] right_in;
   } req_type;

   typedef struct packed {
      logic signed [23:0] left_out;
      logic signed [23:0] right_out;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        mix;
      logic [15:0]        depth;
      logic signed [15:0] feedback;
      logic [19:0]        base_delay;
      logic [15:0]        min_delay;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_K, ST_LFO, ST_DEP, ST_BASE, ST_ADDR, ST_RD, ST_INTERP, ST_FB, ST_WRITE, ST_OUT
   } step_type;

   typedef struct packed {
      logic     run;
      logic     clear;
      step_type step;
   } lane_ctrl_type;

   typedef enum logic [2:0] {
      CSR_BYPASS, CSR_MIX, CSR_LFO_STEP, CSR_DEPTH,
      CSR_FEEDBACK, CSR_BASE_DELAY, CSR_PHASE_OFFSET, CSR_MIN_DELAY
   } csr_index_type;

   localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] SAMPLE_MIN = -24'sh800000;
   localparam logic [63:0] Q30_ONE = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   function automatic step_type next_step(input step_type s);
      case (s)
         ST_K:      next_step = ST_LFO;
         ST_LFO:    next_step = ST_DEP;
         ST_DEP:    next_step = ST_BASE;
         ST_BASE:   next_step = ST_ADDR;
         ST_ADDR:   next_step = ST_RD;
         ST_RD:     next_step = ST_INTERP;
         ST_INTERP: next_step = ST_FB;
         ST_FB:     next_step = ST_WRITE;
         ST_WRITE:  next_step = ST_OUT;
         default:   next_step = ST_K;
      endcase
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
      if (v > 48'(SAMPLE_MAX)) begin
         sat24 = SAMPLE_MAX;
      end else if (v < 48'(SAMPLE_MIN)) begin
         sat24 = SAMPLE_MIN;
      end else begin
         sat24 = v[23:0];
      end
   endfunction

   // Q30 Horner sine series, evaluated at elaboration for table entries.
   function automatic logic [15:0] sine_q15(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      v  = (s * 64'd32768 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      sine_q15 = v[15:0];
   endfunction

endpackage

[rtl/core/sfd_lane.sv]
// One channel of the flanger: LFO lookup, delay, interpolated read,
// feedback write-back and wet/dry mix. Depends on sfd_pkg.
`include "stereo_flanger_delay_unit_macros.svh"

module sfd_lane #(
   parameter int DELAY_DEPTH     = 4096,
   parameter int SINE_TABLE_SIZE = 256
) (
   input  logic                             clock,
   input  sfd_pkg::lane_ctrl_type           ctrl,
   input  sfd_pkg::cfg_type                 cfg,
   input  logic [31:0]                      phase,
   input  logic [$clog2(DELAY_DEPTH)-1:0]   wr_ptr,
   input  logic [$clog2(DELAY_DEPTH)-1:0]   clr_addr,
   input  logic signed [23:0]               dry,
   output logic signed [23:0]               wet_mix
);
   import sfd_pkg::*;

   localparam int AW = $clog2(DELAY_DEPTH);
   localparam int DW = AW + 8;
   localparam int KW = $clog2(SINE_TABLE_SIZE + 1);
   localparam logic [AW-1:0] LAST = AW'(DELAY_DEPTH - 1);
   localparam logic signed [25:0] HI_S = 26'((DELAY_DEPTH - 1) * 256);
   localparam logic [DW+1:0] SPAN = (DW+2)'(DELAY_DEPTH * 256);
   localparam logic [KW-1:0] TAB_N = KW'(SINE_TABLE_SIZE);

   logic [15:0] sine_tab [0:SINE_TABLE_SIZE];

   for (genvar g = 0; g <= SINE_TABLE_SIZE; g++) begin : g_tab
      localparam logic [63:0] X = (HALF_PI_Q30 * 64'(g)) / 64'(SINE_TABLE_SIZE);
      assign sine_tab[g] = sine_q15(X);
   end

   logic signed [23:0] mem [0:DELAY_DEPTH-1];

   logic [29+KW:0]     kp_ff, kp_in;
   logic [1:0]         quad_ff;
   logic signed [16:0] lfo_ff, lfo_in;
   logic signed [33:0] ld_ff, ld_in;
   logic signed [54:0] bp_ff, bp_in;
   logic [DW-1:0]      dc_ff, dc_in;
   logic [7:0]         fr_ff;
   logic signed [23:0] a_ff, b_ff;
   logic signed [23:0] wet_ff, wet_in;
   logic signed [39:0] fbp_ff, fbp_in;
   logic signed [41:0] mixp_ff, mixp_in;
   logic signed [23:0] out_ff, out_in;

   logic [KW-1:0]      k_idx, tab_idx;
   logic signed [16:0] tab_s, depth_s, mix_s;
   logic signed [20:0] base_s;
   logic signed [54:0] off_full;
   logic signed [25:0] d_s, min_s, d_lo, d_cl;
   logic [DW+1:0]      rp_raw, rp;
   logic [AW-1:0]      i1, i2;
   logic signed [9:0]  w1, w2;
   logic signed [33:0] acc;
   logic signed [24:0] diff;
   logic signed [23:0] wr_val;
   logic signed [15:0] fb_s;

   always_comb begin
      kp_in   = (30+KW)'(phase[29:0]) * (30+KW)'(SINE_TABLE_SIZE);
      k_idx   = kp_ff[29+KW:30];
      tab_idx = quad_ff[0] ? TAB_N - k_idx : k_idx;
      tab_s   = {1'b0, sine_tab[tab_idx]};
      lfo_in  = quad_ff[1] ? -tab_s : tab_s;

      depth_s = {1'b0, cfg.depth};
      ld_in   = lfo_ff * depth_s;
      base_s  = {1'b0, cfg.base_delay};
      bp_in   = ld_ff * base_s;

      // floor of the offset, then clamp; the upper bound wins
      off_full = bp_ff >>> 30;
      d_s      = off_full[25:0] + 26'({1'b0, cfg.base_delay});
      min_s    = {10'b0, cfg.min_delay};
      d_lo     = (d_s < min_s) ? min_s : d_s;
      d_cl     = (d_lo > HI_S) ? HI_S : d_lo;
      dc_in    = d_cl[DW-1:0];

      rp_raw = {2'b0, wr_ptr, 8'b0} - {2'b0, dc_ff};
      rp     = rp_raw[DW+1] ? rp_raw + SPAN : rp_raw;
      i1     = rp[DW-1:8];
      i2     = (i1 == LAST) ? '0 : i1 + 1'b1;

      w1     = 10'(9'd256 - {1'b0, fr_ff});
      w2     = {2'b0, fr_ff};
      acc    = a_ff * w1 + b_ff * w2;
      wet_in = 24'(acc >>> 8);

      fb_s   = cfg.feedback;
      fbp_in = wet_ff * fb_s;
      wr_val = sat24(48'(dry) + 48'(fbp_ff >>> 15));

      mix_s   = {1'b0, cfg.mix};
      diff    = 25'(wet_ff) - 25'(dry);
      mixp_in = diff * mix_s;
      out_in  = sat24(48'(dry) + 48'(mixp_ff >>> 15));
   end

   always_ff @(posedge clock) begin
      if (ctrl.run) begin
         case (ctrl.step)
            ST_K: begin
               kp_ff   <= kp_in;
               quad_ff <= phase[31:30];
            end
            ST_LFO:    lfo_ff <= lfo_in;
            ST_DEP:    ld_ff <= ld_in;
            ST_BASE:   bp_ff <= bp_in;
            ST_ADDR:   dc_ff <= dc_in;
            ST_RD:     fr_ff <= rp[7:0];
            ST_INTERP: wet_ff <= wet_in;
            ST_FB:     fbp_ff <= fbp_in;
            ST_WRITE:  mixp_ff <= mixp_in;
            ST_OUT:    out_ff <= out_in;
            default: ;
         endcase
      end
   end

   // read both taps before this item's write lands
   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         mem[clr_addr] <= '0;
      end else if (ctrl.run && ctrl.step == ST_WRITE) begin
         mem[wr_ptr] <= wr_val;
      end
      if (ctrl.run && ctrl.step == ST_RD) begin
         a_ff <= mem[i1];
         b_ff <= mem[i2];
      end
   end

   assign wet_mix = out_ff;

   `SFD_ASSERT_NOW(a_no_clear_run, clock, 1'b0, ctrl.clear, !ctrl.run)
   `SFD_ASSERT_NOW(a_clamp_range, clock, 1'b0, ctrl.run && ctrl.step == ST_ADDR, d_cl <= HI_S)
   `SFD_ASSERT_NOW(a_taps_in_range, clock, 1'b0, ctrl.run && ctrl.step == ST_RD, rp < SPAN)

endmodule

[rtl/core/stereo_flanger_delay_unit.sv]
// Stereo flanger: both lanes run the ten-step sequence in parallel (multiplies and memory read)
// for each item; a new request is taken only in the idle state, once the done state has loaded the result.
// Bypassed items go from idle straight to the done state and leave pointer, phase and delay stores untouched.
// Reset (synchronous) restores register defaults, then clears all DELAY_DEPTH entries of both delay stores
// while req_stall is high; configuration writes are still taken.
// Depends on sfd_pkg and sfd_lane.
`include "stereo_flanger_delay_unit_macros.svh"

module stereo_flanger_delay_unit #(
   parameter int DELAY_DEPTH     = 4096,
   parameter int SINE_TABLE_SIZE = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sfd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sfd_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [23:0]      csr_wdata
);
   import sfd_pkg::*;

   localparam int AW = $clog2(DELAY_DEPTH);
   localparam logic [AW-1:0] LAST = AW'(DELAY_DEPTH - 1);

   typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RUN, S_DONE} state_type;

   state_type     state_ff;
   step_type      step_ff;
   logic [AW-1:0] clr_ff, wp_ff;
   logic [31:0]   phase_ff;
   logic          byp_ff;
   req_type       req_item_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic          bypass_ff;
   logic [15:0]   mix_ff, depth_ff, phase_offset_ff, min_delay_ff;
   logic [23:0]   lfo_step_ff;
   logic [15:0]   feedback_ff;
   logic [19:0]   base_delay_ff;

   cfg_type       cfg;
   lane_ctrl_type lane_ctrl;
   logic [31:0]   right_phase;
   logic signed [23:0] left_wet, right_wet;
   logic          req_take, rsp_free;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign cfg.mix        = mix_ff;
   assign cfg.depth      = depth_ff;
   assign cfg.feedback   = feedback_ff;
   assign cfg.base_delay = base_delay_ff;
   assign cfg.min_delay  = min_delay_ff;

   assign lane_ctrl.run   = (state_ff == S_RUN);
   assign lane_ctrl.clear = (state_ff == S_CLEAR);
   assign lane_ctrl.step  = step_ff;

   assign right_phase = phase_ff + {phase_offset_ff, 16'h0000};

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff       <= 1'b0;
         mix_ff          <= 16'd16384;
         lfo_step_ff     <= 24'd44739;
         depth_ff        <= 16'd22938;
         feedback_ff     <= 16'd16384;
         base_delay_ff   <= 20'd61440;
         phase_offset_ff <= 16'd16384;
         min_delay_ff    <= 16'd1229;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_BYPASS:       bypass_ff <= csr_wdata[0];
            CSR_MIX:          mix_ff <= csr_wdata[15:0];
            CSR_LFO_STEP:     lfo_step_ff <= csr_wdata;
            CSR_DEPTH:        depth_ff <= csr_wdata[15:0];
            CSR_FEEDBACK:     feedback_ff <= csr_wdata[15:0];
            CSR_BASE_DELAY:   base_delay_ff <= csr_wdata[19:0];
            CSR_PHASE_OFFSET: phase_offset_ff <= csr_wdata[15:0];
            CSR_MIN_DELAY:    min_delay_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         step_ff      <= ST_K;
         clr_ff       <= '0;
         wp_ff        <= '0;
         phase_ff     <= '0;
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the done state reloads the result register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == LAST) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_take) begin
                  req_item_ff <= req_payload;
                  byp_ff      <= bypass_ff;
                  step_ff     <= ST_K;
                  state_ff    <= bypass_ff ? S_DONE : S_RUN;
               end
            end
            S_RUN: begin
               step_ff <= next_step(step_ff);
               if (step_ff == ST_OUT) begin
                  // advance pointer and phase once both lanes are through
                  wp_ff    <= (wp_ff == LAST) ? '0 : wp_ff + 1'b1;
                  phase_ff <= phase_ff + {8'h00, lfo_step_ff};
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff.left_out  <= byp_ff ? req_item_ff.left_in : left_wet;
                  rsp_ff.right_out <= byp_ff ? req_item_ff.right_in : right_wet;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   sfd_lane #(
      .DELAY_DEPTH     (DELAY_DEPTH),
      .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
   ) u_left (
      .clock    (clock),
      .ctrl     (lane_ctrl),
      .cfg      (cfg),
      .phase    (phase_ff),
      .wr_ptr   (wp_ff),
      .clr_addr (clr_ff),
      .dry      (req_item_ff.left_in),
      .wet_mix  (left_wet)
   );

   sfd_lane #(
      .DELAY_DEPTH     (DELAY_DEPTH),
      .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
   ) u_right (
      .clock    (clock),
      .ctrl     (lane_ctrl),
      .cfg      (cfg),
      .phase    (right_phase),
      .wr_ptr   (wp_ff),
      .clr_addr (clr_ff),
      .dry      (req_item_ff.right_in),
      .wet_mix  (right_wet)
   );

   `SFD_ASSERT_NEXT(a_start_run, clock, reset, req_take && !bypass_ff, state_ff == S_RUN && step_ff == ST_K)
   `SFD_ASSERT_NEXT(a_wp_hold, clock, reset, !$past(reset) && !(state_ff == S_RUN && step_ff == ST_OUT), $stable(wp_ff))
   `SFD_ASSERT_NOW(a_clear_quiet, clock, reset, state_ff == S_CLEAR, !rsp_valid_ff)

endmodule

[verif/tb.sv]
// Self-checking testbench for stereo_flanger_delay_unit: directed table, then random phases.
// Depends on sfd_pkg and the flanger RTL; predicts each stereo pair in SystemVerilog.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sfd_pkg::*;

   localparam int MEM_DEPTH = 4096;
   localparam int SINE_N    = 256;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_payload;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [23:0] csr_wdata;

   stereo_flanger_delay_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic               m_bypass;
   logic [15:0]        m_mix;
   logic [23:0]        m_step;
   logic [15:0]        m_depth;
   logic signed [15:0] m_feedback;
   logic [19:0]        m_base;
   logic [15:0]        m_offset;
   logic [15:0]        m_min;
   longint             delay_mem [2][MEM_DEPTH];
   int unsigned        wr_ptr;
   logic [31:0]        lfo_phase;
   longint             quarter_sine [SINE_N + 1];

   rsp_type expected_pairs [$];
   int      mismatch_count;
   int      rsp_seen;
   int      idle_max;

   typedef struct {
      bit            is_cfg;
      csr_index_type idx;
      int            val;
      int            l;
      int            r;
      bit            typed;
      int            el;
      int            er;
   } row_type;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #7_200_000;
      $display("FAILURE");
      $finish;
   end

   task automatic build_quarter_sine();
      longint unsigned x, x2, t, s, v;
      for (int i = 0; i <= SINE_N; i++) begin
         x  = (64'd1686629713 * i) / SINE_N;
         x2 = (x * x) >> 30;
         t  = 64'd1073741824 - x2 / 110;
         t  = 64'd1073741824 - ((x2 * t) >> 30) / 72;
         t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
         t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
         t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
         s  = (x * t) >> 30;
         v  = (s * 32768 + (64'd1 << 29)) >> 30;
         quarter_sine[i] = (v > 32767) ? 32767 : longint'(v);
      end
   endtask

   function automatic longint clip24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic longint sine_at(logic [31:0] ph);
      int unsigned k;
      longint      v;
      k = ph[29:22];
      v = quarter_sine[ph[30] ? SINE_N - k : k];
      return ph[31] ? -v : v;
   endfunction

   function automatic longint flange_lane(int ch, longint dry, logic [31:0] ph);
      longint d, rp, fr, wet;
      int     i1, i2;
      d = longint'(m_base) + ((longint'(m_base) * (sine_at(ph) * longint'(m_depth))) >>> 30);
      if (d < longint'(m_min)) d = longint'(m_min);
      if (d > ((MEM_DEPTH - 1) << 8)) d = (MEM_DEPTH - 1) << 8;
      rp = (longint'(wr_ptr) << 8) - d;
      if (rp < 0) rp += MEM_DEPTH << 8;
      i1  = (rp >>> 8) % MEM_DEPTH;
      i2  = (i1 + 1) % MEM_DEPTH;
      fr  = rp & 255;
      wet = (delay_mem[ch][i1] * (256 - fr) + delay_mem[ch][i2] * fr) >>> 8;
      delay_mem[ch][wr_ptr] = clip24(dry + ((wet * longint'(m_feedback)) >>> 15));
      return clip24(dry + ((longint'(m_mix) * (wet - dry)) >>> 15));
   endfunction

   function automatic rsp_type flange_pair(req_type x);
      rsp_type y;
      if (m_bypass) begin
         y.left_out  = x.left_in;
         y.right_out = x.right_in;
      end else begin
         y.left_out  = 24'(flange_lane(0, longint'(x.left_in), lfo_phase));
         y.right_out = 24'(flange_lane(1, longint'(x.right_in), lfo_phase + {m_offset, 16'h0}));
         wr_ptr      = (wr_ptr + 1) % MEM_DEPTH;
         lfo_phase   = lfo_phase + 32'(m_step);
      end
      return y;
   endfunction

   task automatic model_reset();
      m_bypass = 0; m_mix = 16384; m_step = 44739; m_depth = 22938;
      m_feedback = 16384; m_base = 61440; m_offset = 16384; m_min = 1229;
      foreach (delay_mem[c, i]) delay_mem[c][i] = 0;
      wr_ptr = 0;
      lfo_phase = 0;
   endtask

   task automatic model_write(csr_index_type idx, logic [23:0] v);
      case (idx)
         CSR_BYPASS:       m_bypass   = v[0];
         CSR_MIX:          m_mix      = v[15:0];
         CSR_LFO_STEP:     m_step     = v;
         CSR_DEPTH:        m_depth    = v[15:0];
         CSR_FEEDBACK:     m_feedback = v[15:0];
         CSR_BASE_DELAY:   m_base     = v[19:0];
         CSR_PHASE_OFFSET: m_offset   = v[15:0];
         default:          m_min      = v[15:0];
      endcase
   endtask

   // called at a falling edge; returns at a falling edge with csr_we low
   task automatic write_reg(csr_index_type idx, logic [23:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      model_write(idx, v);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // drop the offer, then hold until every pair is back and the sequencer has drained
   task automatic wait_quiet();
      req_valid <= 1'b0;
      wait (expected_pairs.size() == 0);
      repeat (30) @(negedge clock);
   endtask

   task automatic send_pair(int l, int r);
      int gap;
      req_type x;
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      x.left_in  = l[23:0];
      x.right_in = r[23:0];
      req_valid   <= 1'b1;
      req_payload <= x;
      do @(posedge clock); while (req_stall);
      expected_pairs.insert(expected_pairs.size(), flange_pair(x));
      @(negedge clock);
   endtask

   function automatic int any_sample();
      case ($urandom_range(0, 5))
         0:       return 8388607;
         1:       return -8388608;
         2:       return $signed($urandom_range(0, 255)) - 128;
         default: return $signed({$urandom()} << 8) >>> 8;
      endcase
   endfunction

   function automatic logic [23:0] random_setting(csr_index_type idx);
      int pick;
      pick = $urandom_range(0, 7);
      case (idx)
         CSR_BYPASS:       return ($urandom_range(0, 5) == 0);
         CSR_MIX:          return pick == 0 ? 0 : pick == 1 ? 32768 : pick == 2 ? 65535
                                  : $urandom_range(0, 32768);
         CSR_LFO_STEP:     return pick == 0 ? 24'hFFFFFF : pick < 3 ? $urandom_range(0, 4095)
                                  : $urandom_range(0, 24'hFFFFFF);
         CSR_DEPTH:        return pick == 0 ? 0 : pick == 1 ? 65535 : $urandom_range(0, 32768);
         CSR_FEEDBACK:     return pick == 0 ? 24'h007EB8 : pick == 1 ? 24'h008148
                                  : pick == 2 ? 24'h008000 : $urandom_range(0, 24'hFFFFFF);
         CSR_BASE_DELAY:   return pick == 0 ? 0 : pick == 1 ? 24'hFFFFF
                                  : pick < 4 ? $urandom_range(0, 2048)
                                  : $urandom_range(0, 1048320);
         CSR_PHASE_OFFSET: return pick == 0 ? 0 : pick == 1 ? 65535 : $urandom_range(0, 32768);
         default:          return pick == 0 ? 26 : pick == 1 ? 65535
                                  : $urandom_range(26, 4000);
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (expected_pairs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected pair %h", rsp_payload);
         end else begin
            want = expected_pairs.pop_front();
            if (rsp_payload.left_out !== want.left_out ||
                rsp_payload.right_out !== want.right_out) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected L %0d R %0d, got L %0d R %0d",
                           want.left_out, want.right_out,
                           rsp_payload.left_out, rsp_payload.right_out);
            end
         end
      end
   end

   // receiver back-pressure, with one long hold-off to fill the block
   initial begin
      int n;
      bit held;
      rsp_stall = 1'b0;
      held = 0;
      @(negedge clock);
      forever begin
         n = $urandom_range(0, idle_max);
         if (!held && rsp_seen >= 300) begin
            held = 1;
            n = 250;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   initial begin
      row_type rows [$];
      csr_index_type idx;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      mismatch_count = 0;
      rsp_seen = 0;
      idle_max = 9;
      build_quarter_sine();
      model_reset();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      rows = '{
         '{0, CSR_BYPASS, 0, 0, 0, 1, 0, 0},
         '{0, CSR_BYPASS, 0, 8388607, -8388608, 1, 4194303, -4194304},
         '{0, CSR_BYPASS, 0, -8388608, 8388607, 0, 0, 0},
         '{0, CSR_BYPASS, 0, -1, 1, 0, 0, 0},
         '{1, CSR_BYPASS, 1, 0, 0, 0, 0, 0},
         '{0, CSR_BYPASS, 0, 8388607, -8388608, 1, 8388607, -8388608},
         '{0, CSR_BYPASS, 0, 1193046, -5, 1, 1193046, -5},
         '{1, CSR_BYPASS, 0, 0, 0, 0, 0, 0},
         // delay below one sample: partner read at the write pointer
         '{1, CSR_BASE_DELAY, 0, 0, 0, 0, 0, 0},
         '{1, CSR_MIN_DELAY, 26, 0, 0, 0, 0, 0},
         '{0, CSR_BYPASS, 0, 4000000, -4000000, 0, 0, 0},
         '{0, CSR_BYPASS, 0, -8388608, 8388607, 0, 0, 0},
         // out-of-range gains and upper clamp
         '{1, CSR_FEEDBACK, 32768, 0, 0, 0, 0, 0},
         '{1, CSR_MIX, 65535, 0, 0, 0, 0, 0},
         '{1, CSR_DEPTH, 65535, 0, 0, 0, 0, 0},
         '{1, CSR_BASE_DELAY, 1048575, 0, 0, 0, 0, 0},
         '{1, CSR_PHASE_OFFSET, 65535, 0, 0, 0, 0, 0},
         '{1, CSR_LFO_STEP, 16777215, 0, 0, 0, 0, 0},
         '{0, CSR_BYPASS, 0, 8388607, 8388607, 0, 0, 0},
         '{0, CSR_BYPASS, 0, -8388608, -8388608, 0, 0, 0},
         '{1, CSR_FEEDBACK, 32767, 0, 0, 0, 0, 0},
         '{1, CSR_MIX, 0, 0, 0, 0, 0, 0},
         '{0, CSR_BYPASS, 0, 8388607, -8388608, 0, 0, 0},
         '{1, CSR_MIX, 32768, 0, 0, 0, 0, 0},
         '{0, CSR_BYPASS, 0, 1234567, -7654321, 0, 0, 0}
      };
      foreach (rows[i]) begin
         if (rows[i].is_cfg) begin
            wait_quiet();
            write_reg(rows[i].idx, rows[i].val[23:0]);
         end else begin
            if (rows[i].typed) begin
               // typed rows replace the predicted value with the one read off by hand
               send_pair(rows[i].l, rows[i].r);
               expected_pairs[$].left_out  = rows[i].el[23:0];
               expected_pairs[$].right_out = rows[i].er[23:0];
            end else begin
               send_pair(rows[i].l, rows[i].r);
            end
         end
      end

      for (int phase = 0; phase < 8; phase++) begin
         wait_quiet();
         req_valid <= 1'b0;
         idle_max = (phase % 3 == 2) ? 0 : 9;
         for (int k = 0; k < 8; k++) begin
            idx = csr_index_type'(k);
            write_reg(idx, random_setting(idx));
         end
         for (int n = 0; n < 130; n++) send_pair(any_sample(), any_sample());
      end
      req_valid <= 1'b0;

      wait (expected_pairs.size() == 0);
      repeat (30) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
